@@ design/dund_pkg.sv @@
// shared types, constants and calendar helpers for days_until_next_date
// no dependencies

package dund_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DAYS_W  = 10;
  localparam int unsigned REM_W   = 9;   // holds year mod 400
  localparam int unsigned SHIFT_W = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MAX     = {YEAR_W{1'b1}};
  localparam logic [YEAR_W-1:0]  LEAP_PERIOD  = YEAR_W'(400);
  localparam logic [REM_W-1:0]   REM_LAST     = REM_W'(399);
  localparam logic [REM_W-1:0]   CENTURY_1    = REM_W'(100);
  localparam logic [REM_W-1:0]   CENTURY_2    = REM_W'(200);
  localparam logic [REM_W-1:0]   CENTURY_3    = REM_W'(300);
  localparam logic [SHIFT_W-1:0] REDUCE_TOP   = SHIFT_W'(5);
  localparam logic [DAY_W-1:0]   FIRST_DAY    = DAY_W'(1);
  localparam logic [MONTH_W-1:0] JANUARY      = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY     = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER     = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   LONG_MONTH   = DAY_W'(31);
  localparam logic [DAY_W-1:0]   LEAP_FEB     = DAY_W'(29);

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  typedef struct packed {
    logic               load;
    logic               reduce;
    logic [SHIFT_W-1:0] reduce_k;
    logic               walk;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic at_limit;
  } status_t;

  // leap test from year mod 400
  function automatic logic leap_from_rem(input logic [REM_W-1:0] rem);
    leap_from_rem = (rem[1:0] == 2'b00) && (rem != CENTURY_1) &&
                    (rem != CENTURY_2) && (rem != CENTURY_3);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - JANUARY;
    if (m < JANUARY || m > DECEMBER) begin
      month_days = LONG_MONTH;
    end else if (m == FEBRUARY && leap) begin
      month_days = LEAP_FEB;
    end else begin
      month_days = MONTH_LEN[idx];
    end
  endfunction

endpackage

@@ design/dund_ctrl.sv @@
// controller fsm for days_until_next_date: sequences reduce, walk and result
// depends on dund_pkg

module dund_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dund_pkg::status_t status_i,
  output dund_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  dund_pkg::state_e                state_q, state_d;
  logic [dund_pkg::SHIFT_W-1:0]    k_q, k_d;

  always_comb begin
    state_d         = state_q;
    k_d             = k_q;
    cmd_o.load      = 1'b0;
    cmd_o.reduce    = 1'b0;
    cmd_o.reduce_k  = k_q;
    cmd_o.walk      = 1'b0;
    case (state_q)
      dund_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          k_d        = dund_pkg::REDUCE_TOP;
          state_d    = dund_pkg::ST_REDUCE;
        end
      end
      dund_pkg::ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (k_q == '0) begin
          state_d = dund_pkg::ST_WALK;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      dund_pkg::ST_WALK: begin
        if (status_i.match) begin
          state_d = dund_pkg::ST_DONE;
        end else begin
          cmd_o.walk = 1'b1;
          // this step pushes the count past the limit
          if (status_i.at_limit) begin
            state_d = dund_pkg::ST_DONE;
          end
        end
      end
      dund_pkg::ST_DONE: begin
        state_d = dund_pkg::ST_IDLE;
      end
      default: begin
        state_d = dund_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dund_pkg::ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  assign busy_o = (state_q != dund_pkg::ST_IDLE);
  assign done_o = (state_q == dund_pkg::ST_DONE);

endmodule

@@ design/dund_datapath.sv @@
// datapath for days_until_next_date: date registers, year mod 400 reduction,
// one-day step logic, step counter and result registers; depends on dund_pkg

module dund_datapath #(
  parameter int unsigned MAX_STEPS = 732
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dund_pkg::cmd_t                 cmd_i,
  output dund_pkg::status_t              status_o,
  input  logic [dund_pkg::DAY_W-1:0]     today_day_i,
  input  logic [dund_pkg::MONTH_W-1:0]   today_month_i,
  input  logic [dund_pkg::YEAR_W-1:0]    today_year_i,
  input  logic [dund_pkg::DAY_W-1:0]     goal_day_i,
  input  logic [dund_pkg::MONTH_W-1:0]   goal_month_i,
  output logic [dund_pkg::YEAR_W-1:0]    goal_year_o,
  output logic [dund_pkg::DAYS_W-1:0]    days_until_o,
  output logic                           unreachable_o
);

  localparam int unsigned CNT_RAW = $clog2(MAX_STEPS + 2);
  localparam int unsigned CNT_W   = (CNT_RAW > dund_pkg::DAYS_W) ? CNT_RAW : dund_pkg::DAYS_W;
  localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(MAX_STEPS);
  localparam logic [CNT_W-1:0] DAYS_SAT = CNT_W'({dund_pkg::DAYS_W{1'b1}});

  logic [dund_pkg::DAY_W-1:0]   day_q, goal_day_q;
  logic [dund_pkg::MONTH_W-1:0] month_q, goal_month_q;
  logic [dund_pkg::YEAR_W-1:0]  year_q, goal_year_q, rem_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         lost_q;

  logic                         passed;
  logic [dund_pkg::YEAR_W-1:0]  goal_year_in;
  logic [dund_pkg::YEAR_W-1:0]  sub;
  logic [dund_pkg::REM_W-1:0]   rem400;
  logic                         leap;
  logic [dund_pkg::DAY_W-1:0]   mdays;
  logic [dund_pkg::DAY_W:0]     day_inc;
  logic [dund_pkg::MONTH_W:0]   month_inc;
  logic [dund_pkg::DAY_W-1:0]   day_n;
  logic [dund_pkg::MONTH_W-1:0] month_n;
  logic [dund_pkg::YEAR_W-1:0]  year_n;
  logic [dund_pkg::YEAR_W-1:0]  rem_n;
  logic                         new_year;

  assign passed = (goal_month_i < today_month_i) ||
                  ((goal_month_i == today_month_i) && (goal_day_i < today_day_i));
  assign goal_year_in = today_year_i + dund_pkg::YEAR_W'(passed);

  // restoring reduction of the year by 400 << k
  assign sub = dund_pkg::LEAP_PERIOD << cmd_i.reduce_k;

  assign rem400 = rem_q[dund_pkg::REM_W-1:0];
  assign leap   = dund_pkg::leap_from_rem(rem400);
  assign mdays  = dund_pkg::month_days(month_q, leap);

  always_comb begin
    day_inc = {1'b0, day_q} + 1'b1;
    if (day_inc > {1'b0, mdays}) begin
      day_n     = dund_pkg::FIRST_DAY;
      month_inc = {1'b0, month_q} + 1'b1;
    end else begin
      day_n     = day_inc[dund_pkg::DAY_W-1:0];
      month_inc = {1'b0, month_q};
    end
    new_year = (month_inc > {1'b0, dund_pkg::DECEMBER});
    if (new_year) begin
      month_n = dund_pkg::JANUARY;
      year_n  = year_q + 1'b1;
      // rem restarts at zero when the year wraps to zero, a multiple of 400, or when year mod 400 is 399
      if (year_q == dund_pkg::YEAR_MAX || rem400 == dund_pkg::REM_LAST) begin
        rem_n = '0;
      end else begin
        rem_n = rem_q + 1'b1;
      end
    end else begin
      month_n = month_inc[dund_pkg::MONTH_W-1:0];
      year_n  = year_q;
      rem_n   = rem_q;
    end
  end

  assign status_o.match = (day_q == goal_day_q) && (month_q == goal_month_q) &&
                          (year_q == goal_year_q);
  assign status_o.at_limit = (cnt_q >= LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q        <= dund_pkg::FIRST_DAY;
      month_q      <= dund_pkg::JANUARY;
      year_q       <= dund_pkg::YEAR_W'(1);
      goal_day_q   <= '0;
      goal_month_q <= '0;
      goal_year_q  <= '0;
      rem_q        <= dund_pkg::YEAR_W'(1);
      cnt_q        <= '0;
      lost_q       <= 1'b0;
    end else if (cmd_i.load) begin
      day_q        <= today_day_i;
      month_q      <= today_month_i;
      year_q       <= today_year_i;
      goal_day_q   <= goal_day_i;
      goal_month_q <= goal_month_i;
      goal_year_q  <= goal_year_in;
      rem_q        <= today_year_i;
      cnt_q        <= '0;
      lost_q       <= 1'b0;
    end else if (cmd_i.reduce) begin
      if (rem_q >= sub) begin
        rem_q <= rem_q - sub;
      end
    end else if (cmd_i.walk) begin
      day_q   <= day_n;
      month_q <= month_n;
      year_q  <= year_n;
      rem_q   <= rem_n;
      cnt_q   <= cnt_q + 1'b1;
      lost_q  <= status_o.at_limit;
    end
  end

  assign goal_year_o   = goal_year_q;
  assign days_until_o  = (cnt_q > DAYS_SAT) ? dund_pkg::DAYS_W'(DAYS_SAT)
                                            : cnt_q[dund_pkg::DAYS_W-1:0];
  assign unreachable_o = lost_q;

endmodule

@@ design/days_until_next_date.sv @@
// top level of days_until_next_date: counts days from today to the next
// occurrence of a target day and month; depends on dund_pkg, dund_ctrl, dund_datapath
//
// usage
//   an item (today_day_i, today_month_i, today_year_i, goal_day_i, goal_month_i)
//   is taken at a rising edge with start_i high and busy_o low
//   busy_o stays high until the result has been shown
//   the result (goal_year_o, days_until_o, unreachable_o) is valid for exactly
//   one cycle, marked by done_o; the receiver cannot stall it
// sequence
//   the year is first reduced modulo 400 by compare-and-subtract steps with
//   400 << k for k from 5 down to 0, then the walk advances one day per cycle
//   and ends with a final compare on the target, then the result is shown
//   for a single cycle; an unreachable target has no final compare and stops
//   once the step count passes MAX_STEPS
//   the next item can be taken in the cycle after done_o
// reset
//   rst_ni clears the controller to idle; no result is pending after reset

module days_until_next_date #(
  parameter int unsigned MAX_STEPS = 732
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  output logic                           done_o,
  input  logic [dund_pkg::DAY_W-1:0]     today_day_i,
  input  logic [dund_pkg::MONTH_W-1:0]   today_month_i,
  input  logic [dund_pkg::YEAR_W-1:0]    today_year_i,
  input  logic [dund_pkg::DAY_W-1:0]     goal_day_i,
  input  logic [dund_pkg::MONTH_W-1:0]   goal_month_i,
  output logic [dund_pkg::YEAR_W-1:0]    goal_year_o,
  output logic [dund_pkg::DAYS_W-1:0]    days_until_o,
  output logic                           unreachable_o
);

  localparam int unsigned LOST_RAW = MAX_STEPS + 1;
  localparam int unsigned LOST_SAT = (1 << dund_pkg::DAYS_W) - 1;
  localparam logic [dund_pkg::DAYS_W-1:0] DAYS_LOST =
    dund_pkg::DAYS_W'((LOST_RAW > LOST_SAT) ? LOST_SAT : LOST_RAW);

  dund_pkg::cmd_t    cmd;
  dund_pkg::status_t status;

  dund_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  dund_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .today_day_i   (today_day_i),
    .today_month_i (today_month_i),
    .today_year_i  (today_year_i),
    .goal_day_i    (goal_day_i),
    .goal_month_i  (goal_month_i),
    .goal_year_o   (goal_year_o),
    .days_until_o  (days_until_o),
    .unreachable_o (unreachable_o)
  );

  // an unreachable target always reports the saturated limit count
  a_lost_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unreachable_o) |-> (days_until_o == DAYS_LOST))
    else $error("unreachable result with wrong count");

  // a reachable result never exceeds the step limit
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !unreachable_o) |-> (32'(days_until_o) <= MAX_STEPS))
    else $error("reachable result beyond step limit");

  // the result cycle is the last busy cycle of an item
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy_o ##1 !busy_o))
    else $error("done not followed by idle");

  // an accepted item never reports in the very next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("result too early after accept");

endmodule

@@ tb/days_until_next_date_tb.sv @@
`timescale 1ns / 1ps
// testbench for days_until_next_date: feeds date queries, predicts each day count
// with its own calendar walk and checks every result field; depends on dund_pkg and the rtl

module days_until_next_date_tb;

  localparam int unsigned WALK_LIMIT   = 732;
  localparam int unsigned YEAR_SPAN    = 1 << dund_pkg::YEAR_W;
  localparam int unsigned COUNT_TOP    = (1 << dund_pkg::DAYS_W) - 1;
  localparam int unsigned N_RANDOM     = 800;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [dund_pkg::DAY_W-1:0]   today_day;
    logic [dund_pkg::MONTH_W-1:0] today_month;
    logic [dund_pkg::YEAR_W-1:0]  today_year;
    logic [dund_pkg::DAY_W-1:0]   goal_day;
    logic [dund_pkg::MONTH_W-1:0] goal_month;
  } query_t;

  typedef struct packed {
    logic [dund_pkg::YEAR_W-1:0] goal_year;
    logic [dund_pkg::DAYS_W-1:0] days_until;
    logic                        unreachable;
  } span_t;

  logic   clk_i   = 1'b0;
  logic   rst_ni  = 1'b0;
  logic   start_i = 1'b0;
  query_t shown   = '0;
  logic   busy_o, done_o, unreachable_o;
  logic [dund_pkg::YEAR_W-1:0] goal_year_o;
  logic [dund_pkg::DAYS_W-1:0] days_until_o;

  query_t      pending_q [$];
  span_t       forecast_q [$];
  int unsigned gap_left    = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_taken     = 0;
  int unsigned n_checked   = 0;
  int unsigned n_lost      = 0;
  int unsigned n_same      = 0;
  int unsigned errors      = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  days_until_next_date DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .today_day_i   (shown.today_day),
    .today_month_i (shown.today_month),
    .today_year_i  (shown.today_year),
    .goal_day_i    (shown.goal_day),
    .goal_month_i  (shown.goal_month),
    .goal_year_o   (goal_year_o),
    .days_until_o  (days_until_o),
    .unreachable_o (unreachable_o)
  );

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // months outside 1..12 count as 31 days
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 31;
    if (m == 2 && is_leap_year(y)) return 29;
    return len[m-1];
  endfunction

  function automatic span_t days_to_goal(query_t q);
    int unsigned d, m, y, gy, cnt;
    bit passed, lost;
    span_t r;
    passed = (q.goal_month < q.today_month) ||
             (q.goal_month == q.today_month && q.goal_day < q.today_day);
    gy = (int'(q.today_year) + int'(passed)) % YEAR_SPAN;
    d = q.today_day;
    m = q.today_month;
    y = q.today_year;
    cnt = 0;
    lost = 1'b0;
    while (!(d == q.goal_day && m == q.goal_month && y == gy)) begin
      d++;
      if (d > days_in_month(m, y)) begin
        d = 1;
        m++;
      end
      if (m > 12) begin
        m = 1;
        y = (y + 1) % YEAR_SPAN;
      end
      cnt++;
      if (cnt > WALK_LIMIT) begin
        lost = 1'b1;
        break;
      end
    end
    r.goal_year   = dund_pkg::YEAR_W'(gy);
    r.days_until  = dund_pkg::DAYS_W'(cnt > COUNT_TOP ? COUNT_TOP : cnt);
    r.unreachable = lost;
    return r;
  endfunction

  task automatic queue_date(int unsigned td, int unsigned tm, int unsigned ty,
                            int unsigned gd, int unsigned gm);
    query_t q;
    q.today_day   = dund_pkg::DAY_W'(td);
    q.today_month = dund_pkg::MONTH_W'(tm);
    q.today_year  = dund_pkg::YEAR_W'(ty);
    q.goal_day    = dund_pkg::DAY_W'(gd);
    q.goal_month  = dund_pkg::MONTH_W'(gm);
    pending_q = {pending_q, q};
  endtask

  // driver: gaps count down only while the block is free, gap 0 holds start through busy
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic        taken;
    int unsigned gap;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      shown    <= '0;
      gap_left <= 0;
    end else begin
      taken = start_i && !busy_o;
      if (taken) begin
        forecast_q = {forecast_q, days_to_goal(shown)};
        n_taken++;
        // bursts with no idling every third stretch of 40 items
        gap = (n_taken % 120 < 40) ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        gap = gap_left;
      end
      if (start_i && !taken) begin
        // item still waiting for the block
      end else if (gap == 0 && pending_q.size() != 0) begin
        shown    <= pending_q.pop_front();
        start_i  <= 1'b1;
        gap_left <= 0;
      end else begin
        start_i  <= 1'b0;
        shown    <= query_t'($urandom);
        gap_left <= (gap != 0 && !busy_o) ? gap - 1 : gap;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin : check_proc
    span_t want, got;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (done_o) begin
        got = {goal_year_o, days_until_o, unreachable_o};
        if (forecast_q.size() == 0) begin
          $display("%0t: stray result goal_year=%0d days_until=%0d unreachable=%0b",
                   $time, got.goal_year, got.days_until, got.unreachable);
          errors++;
        end else begin
          want = forecast_q.pop_front();
          n_checked++;
          if (want.unreachable) n_lost++;
          if (want.days_until == 0) n_same++;
          if (got.goal_year !== want.goal_year) begin
            $display("%0t: goal_year expected %0d actual %0d",
                     $time, want.goal_year, got.goal_year);
            errors++;
          end
          if (got.days_until !== want.days_until) begin
            $display("%0t: days_until expected %0d actual %0d",
                     $time, want.days_until, got.days_until);
            errors++;
          end
          if (got.unreachable !== want.unreachable) begin
            $display("%0t: unreachable expected %0b actual %0b",
                     $time, want.unreachable, got.unreachable);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no item or result for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : run_proc
    int unsigned pick, td, tm, ty, gd, gm;
    // corner cases
    queue_date(15, 6, 2024, 15, 6);     // target is today
    queue_date(1, 1, 2023, 31, 12);     // whole year ahead
    queue_date(31, 12, 2023, 1, 1);     // rolls into next year
    queue_date(2, 1, 2023, 1, 1);       // target just passed
    queue_date(1, 1, 2024, 29, 2);      // leap day in leap year
    queue_date(1, 3, 2023, 29, 2);      // leap day falls next year
    queue_date(1, 1, 2023, 29, 2);      // leap day in common year
    queue_date(1, 1, 1900, 29, 2);      // century not leap
    queue_date(1, 1, 2000, 29, 2);      // 400-year leap
    queue_date(1, 3, 2099, 29, 2);      // next year is a non-leap century
    queue_date(1, 1, 2023, 31, 4);      // day past month length
    queue_date(5, 5, 2023, 0, 5);       // target day zero
    queue_date(0, 3, 2023, 0, 3);       // invalid target equal to today
    queue_date(30, 2, 2023, 1, 3);      // today past month length
    queue_date(0, 0, 100, 15, 1);       // walk starting in month zero
    queue_date(10, 13, 50, 1, 1);       // month beyond december
    queue_date(31, 15, 16383, 31, 15);  // all-ones today equal to target
    queue_date(31, 12, 16383, 1, 1);    // year wraps to zero
    queue_date(31, 15, 16383, 0, 0);    // wrapped year, never reached
    queue_date(1, 1, 0, 29, 2);         // year zero is leap
    queue_date(1, 1, 1, 1, 1);
    queue_date(31, 12, 9999, 31, 12);
    queue_date(31, 1, 8192, 1, 2);

    repeat (N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        pending_q = {pending_q, query_t'($urandom)};
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) ty = $urandom_range(0, YEAR_SPAN - 1);
        else if (pick < 50) ty = YEAR_SPAN - 1 - $urandom_range(0, 2);
        else ty = ($urandom_range(0, 164) * 100 + $urandom_range(0, 2) + YEAR_SPAN - 1)
                  % YEAR_SPAN;
        tm = $urandom_range(1, 12);
        td = $urandom_range(1, days_in_month(tm, ty));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          gd = td;
          gm = tm;
        end else if (pick < 25) begin
          gm = 2;
          gd = 29;
        end else begin
          gm = $urandom_range(1, 12);
          gd = $urandom_range(1, days_in_month(gm, 2000));
        end
        queue_date(td, tm, ty, gd, gm);
      end
    end

    wait (rst_ni);
    while (pending_q.size() != 0 || start_i || forecast_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("checked %0d results for %0d queries with random start gaps and bursts",
             n_checked, n_taken);
    $display("%0d targets unreachable, %0d already on the target day", n_lost, n_same);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
